// ===== src/b5ga_pkg.sv =====
// Types and constants for the Big5 glyph address calculator.
// Shared by every module of the block; depends on nothing else.
package b5ga_pkg;

  localparam int unsigned NumBases = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned IdxW     = 15;
  localparam int unsigned ProdW    = 23;

  typedef enum logic [1:0] {
    CLS_SINGLE  = 2'd0,
    CLS_SYMBOL  = 2'd1,
    CLS_HANZI   = 2'd2,
    CLS_SYMBOL2 = 2'd3
  } char_class_e;

  // Code range limits of the Big5 plane.
  localparam logic [15:0] CodeLow       = 16'hA100;
  localparam logic [15:0] CodeHigh      = 16'hFA00;
  localparam logic [15:0] CodeHanziLow  = 16'hA3C0;
  localparam logic [15:0] CodeSym2Low   = 16'hC67F;
  localparam logic [15:0] CodeHanziHigh = 16'hC8D4;
  localparam logic [15:0] CodeEnd       = 16'hF9FF;

  // Trail byte ranges.
  localparam logic [7:0] TrailLow     = 8'h40;
  localparam logic [7:0] TrailLowEnd  = 8'h7E;
  localparam logic [7:0] TrailHighBeg = 8'hA1;
  localparam logic [7:0] TrailHighEnd = 8'hFE;
  localparam logic [7:0] ColSplit     = 8'h60;
  localparam logic [7:0] TrailGap     = 8'h22;

  // First lead byte of each font, and the cell bookkeeping.
  localparam logic [7:0] LeadSymbol   = 8'hA1;
  localparam logic [7:0] LeadHanzi    = 8'hA4;
  localparam logic [7:0] LeadSymbol2  = 8'hC6;
  localparam logic [7:0] LeadHanziGap = 8'hC8;
  localparam logic signed [15:0] RowCells    = 16'sd157;
  localparam logic signed [15:0] HanziSkip   = 16'sd408;
  localparam logic signed [15:0] Symbol2Bias = 16'sd63;

  // Bitmap sizes and advances.
  localparam logic [6:0] BytesSingleSmall = 7'd15;
  localparam logic [6:0] BytesSingleLarge = 7'd48;
  localparam logic [6:0] BytesWideSmall   = 7'd30;
  localparam logic [6:0] BytesWideLarge   = 7'd72;
  localparam logic [4:0] AdvSingleSmall   = 5'd8;
  localparam logic [4:0] AdvSingleLarge   = 5'd16;
  localparam logic [4:0] AdvWideSmall     = 5'd16;
  localparam logic [4:0] AdvWideLarge     = 5'd24;
  localparam logic [1:0] ConsumedSingle   = 2'd1;
  localparam logic [1:0] ConsumedWide     = 2'd2;

  typedef struct packed {
    logic [15:0] char_pair;
    logic        large_font;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       char_class;
    logic [AddrW-1:0] glyph_address;
    logic [6:0]       glyph_bytes;
    logic [4:0]       advance_pixels;
    logic [1:0]       bytes_consumed;
  } out_item_t;

  // Decoded character, held between the two register stages.
  typedef struct packed {
    char_class_e            cls;
    logic signed [IdxW-1:0] idx;
    logic                   big_font;
  } dec_t;

  typedef logic [NumBases-1:0][AddrW-1:0] base_bank_t;

endpackage

// ===== src/b5ga_cfg_regs.sv =====
// Font base address registers, written through the plain configuration port.
// Depends on b5ga_pkg.
module b5ga_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [b5ga_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [b5ga_pkg::AddrW-1:0]    cfg_data_i,
  output b5ga_pkg::base_bank_t          bases_o
);
  import b5ga_pkg::*;

  base_bank_t bases_q, bases_d;

  always_comb begin
    bases_d = bases_q;
    if (cfg_we_i) begin
      bases_d[cfg_index_i] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bases_q <= '0;
    end else begin
      bases_q <= bases_d;
    end
  end

  assign bases_o = bases_q;

endmodule

// ===== src/b5ga_decode.sv =====
// Classifies a Big5 byte pair and forms its cell index within the chosen font.
// Depends on b5ga_pkg.
module b5ga_decode (
  input  b5ga_pkg::in_item_t item_i,
  output b5ga_pkg::dec_t     dec_o
);
  import b5ga_pkg::*;

  logic [7:0]         lead;
  logic [7:0]         trail;
  logic [15:0]        code;
  logic [7:0]         col;
  logic               trail_ok;
  char_class_e        cls;
  logic signed [15:0] lead_s;
  logic signed [15:0] col_s;
  logic signed [15:0] idx_w;

  assign lead  = item_i.char_pair[7:0];
  assign trail = item_i.char_pair[15:8];
  assign code  = {lead, trail};

  assign trail_ok = (trail >= TrailLow) && (trail <= TrailHighEnd) &&
                    !((trail > TrailLowEnd) && (trail < TrailHighBeg));

  always_comb begin
    priority if ((code < CodeLow) || (code > CodeHigh) || !trail_ok) begin
      cls = CLS_SINGLE;
    end else if (code < CodeHanziLow) begin
      cls = CLS_SYMBOL;
    end else if (code < CodeSym2Low) begin
      cls = CLS_HANZI;
    end else if (code < CodeHanziHigh) begin
      cls = CLS_SYMBOL2;
    end else if (code < CodeEnd) begin
      cls = CLS_HANZI;
    end else begin
      cls = CLS_SINGLE;
    end
  end

  // The upper trail range follows the lower one without the gap between them.
  always_comb begin
    col = trail - TrailLow;
    if (col > ColSplit) begin
      col = col - TrailGap;
    end
  end

  assign lead_s = signed'({8'd0, lead});
  assign col_s  = signed'({8'd0, col});

  // A3C0..A3FE fall in the hanzi class one row before its first lead byte,
  // so the index goes negative there.
  always_comb begin
    unique case (cls)
      CLS_SYMBOL: begin
        idx_w = (lead_s - signed'({8'd0, LeadSymbol})) * RowCells + col_s;
      end
      CLS_HANZI: begin
        idx_w = (lead_s - signed'({8'd0, LeadHanzi})) * RowCells + col_s;
        if (lead > LeadHanziGap) begin
          idx_w = idx_w - HanziSkip;
        end
      end
      CLS_SYMBOL2: begin
        idx_w = (lead_s - signed'({8'd0, LeadSymbol2})) * RowCells + col_s - Symbol2Bias;
      end
      default: begin
        idx_w = lead_s;
      end
    endcase
  end

  assign dec_o.cls      = cls;
  assign dec_o.idx      = idx_w[IdxW-1:0];
  assign dec_o.big_font = item_i.large_font;

endmodule

// ===== src/b5ga_addr.sv =====
// Scales a decoded cell index by the glyph size and adds the font base.
// Also derives byte count, advance and bytes consumed. Depends on b5ga_pkg.
module b5ga_addr (
  input  b5ga_pkg::dec_t       dec_i,
  input  b5ga_pkg::base_bank_t bases_i,
  output b5ga_pkg::out_item_t  item_o
);
  import b5ga_pkg::*;

  logic                    single;
  logic [6:0]              glyph_sz;
  logic [4:0]              adv;
  logic signed [ProdW-1:0] prod;
  logic [AddrW-1:0]        base;

  assign single = (dec_i.cls == CLS_SINGLE);

  always_comb begin
    unique case ({dec_i.big_font, single})
      2'b01:   begin glyph_sz = BytesSingleSmall; adv = AdvSingleSmall; end
      2'b11:   begin glyph_sz = BytesSingleLarge; adv = AdvSingleLarge; end
      2'b10:   begin glyph_sz = BytesWideLarge;   adv = AdvWideLarge;   end
      default: begin glyph_sz = BytesWideSmall;   adv = AdvWideSmall;   end
    endcase
  end

  // The glyph size is also the per-cell stride of every font.
  assign prod = ProdW'(dec_i.idx) * ProdW'(signed'({1'b0, glyph_sz}));
  assign base = bases_i[{dec_i.big_font, dec_i.cls}];

  assign item_o.char_class     = dec_i.cls;
  assign item_o.glyph_address  = base + {{(AddrW-ProdW){prod[ProdW-1]}}, prod};
  assign item_o.glyph_bytes    = glyph_sz;
  assign item_o.advance_pixels = adv;
  assign item_o.bytes_consumed = single ? ConsumedSingle : ConsumedWide;

endmodule

// ===== src/big5_glyph_address_calc_top.sv =====
// Big5 glyph address calculator: each accepted input beat passes through the
// decode register, then the result register, before its result beat is offered.
// Throughput is one beat per cycle; the input stalls only while a result is
// held by a stalled output and the decode register is full.
// Reset clears both valid flags and sets all eight font bases to zero.
// Depends on b5ga_pkg, b5ga_cfg_regs, b5ga_decode and b5ga_addr.
module big5_glyph_address_calc_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  b5ga_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output b5ga_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [b5ga_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [b5ga_pkg::AddrW-1:0]    cfg_data_i
);
  import b5ga_pkg::*;

  base_bank_t bases;
  dec_t       dec;
  dec_t       s1_q, s1_d;
  logic       s1_valid_q, s1_valid_d;
  out_item_t  res;
  out_item_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic       out_ready;
  logic       s1_ready;
  logic       in_accept;

  b5ga_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bases_o     (bases)
  );

  b5ga_decode u_decode (
    .item_i (in_data_i),
    .dec_o  (dec)
  );

  b5ga_addr u_addr (
    .dec_i   (s1_q),
    .bases_i (bases),
    .item_o  (res)
  );

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign in_accept = in_valid_i && s1_ready;

  always_comb begin
    s1_d        = s1_q;
    s1_valid_d  = s1_valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        out_d = res;
      end
      s1_valid_d = 1'b0;
    end
    if (in_accept) begin
      s1_d       = dec;
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign in_stall_o  = !s1_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/b5ga_checker.sv =====
// Port-level checks for the Big5 glyph address calculator, bound to the top.
// Depends on b5ga_pkg and big5_glyph_address_calc_top.
module b5ga_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input b5ga_pkg::out_item_t           out_data_o
);
  import b5ga_pkg::*;

  // A result beat that is stalled stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat was dropped or changed");

  // The input side only stalls under back pressure from a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back pressure");

  // Single-byte characters consume one byte, all others two.
  a_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.char_class == CLS_SINGLE) ==
                     (out_data_o.bytes_consumed == ConsumedSingle)))
    else $error("bytes consumed disagrees with character class");

  // Byte count and advance must come from the same font size.
  a_size_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.glyph_bytes == BytesSingleSmall &&
        out_data_o.advance_pixels == AdvSingleSmall) ||
       (out_data_o.glyph_bytes == BytesSingleLarge &&
        out_data_o.advance_pixels == AdvSingleLarge) ||
       (out_data_o.glyph_bytes == BytesWideSmall &&
        out_data_o.advance_pixels == AdvWideSmall) ||
       (out_data_o.glyph_bytes == BytesWideLarge &&
        out_data_o.advance_pixels == AdvWideLarge)))
    else $error("glyph byte count and advance do not match");

endmodule

bind big5_glyph_address_calc_top b5ga_checker u_b5ga_checker (.*);
